### design/tgh_pkg.sv
// ----------------------------------------------------------------------------
// tgh_pkg
// Shared types and constants of the transmit gate and hop schedule engine.
// ----------------------------------------------------------------------------
package tgh_pkg;

  localparam int unsigned SAMPLE_W = 48;
  localparam int unsigned FREQ_W   = 40;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned DIV_CNT_W = $clog2(SAMPLE_W + 1);

  localparam int unsigned MAX_EVENTS_DEF = 32;
  localparam int unsigned MAX_HOPS_DEF   = 16;
  localparam int unsigned MAX_FREQS_DEF  = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 3'd0,
    KIND_EVENT = 3'd1,
    KIND_HOP   = 3'd2,
    KIND_ENTRY = 3'd3,
    KIND_QUERY = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_CONFLICT   = 3'd1,
    ST_ZERO_DWELL = 3'd2,
    ST_REPEAT     = 3'd3,
    ST_FULL       = 3'd4
  } status_e;

  typedef struct packed {
    logic                start;
    logic [SAMPLE_W-1:0] dividend;
    logic [SAMPLE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [SAMPLE_W-1:0] quot;
    logic [SAMPLE_W-1:0] rem;
  } div_rsp_t;

endpackage

### design/tgh_if.sv
// ----------------------------------------------------------------------------
// tgh channel interfaces
// Valid/ready channels for items, results and the base frequency register.
// ----------------------------------------------------------------------------
interface tgh_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [47:0] sample_index;
  logic        tx_state;
  logic        fixed_center;
  logic [47:0] dwell_samples;
  logic [39:0] frequency;

  modport source (output valid, kind, sample_index, tx_state, fixed_center,
                  dwell_samples, frequency, input ready);
  modport sink (input valid, kind, sample_index, tx_state, fixed_center,
                dwell_samples, frequency, output ready);
endinterface

interface tgh_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        tx_on;
  logic [39:0] center_frequency;
  logic [47:0] next_change;
  logic        has_next_change;

  modport source (output valid, status, tx_on, center_frequency, next_change,
                  has_next_change, input ready);
  modport sink (input valid, status, tx_on, center_frequency, next_change,
                has_next_change, output ready);
endinterface

interface tgh_cfg_if;
  logic        valid;
  logic        ready;
  logic [39:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### design/tx_gate_and_hop_schedule.sv
// ----------------------------------------------------------------------------
// tx_gate_and_hop_schedule
// Emitter timeline engine: loads transmit events and hops, answers queries.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                         | handshake
//  in_ch    | in  | kind, sample_index, tx_state, fixed_center,     | valid/ready
//           |     | dwell_samples, frequency                        |
//  out_ch   | out | status, tx_on, center_frequency, next_change,   | valid/ready
//           |     | has_next_change                                 |
//  cfg_ch   | in  | data (base frequency)                           | valid/ready
//
// Load, clear and unknown items are answered without leaving the idle state. A
// query runs an event scan, a forward hop scan, a backward hop scan and, for
// a hop sequence, two passes through the shared bit-serial divider; the scans
// are bounded by the event/hop fill counts E/H.
// Reset clears all counts and the base frequency; tables need no clearing.
// A finished result waits in the output register; in_ch stalls only while a
// query runs or the output register is full and not taken.
// ----------------------------------------------------------------------------
module tx_gate_and_hop_schedule
  import tgh_pkg::*;
#(
  parameter int unsigned MAX_EVENTS = MAX_EVENTS_DEF,
  parameter int unsigned MAX_HOPS   = MAX_HOPS_DEF,
  parameter int unsigned MAX_FREQS  = MAX_FREQS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  tgh_in_if.sink    in_ch,
  tgh_out_if.source out_ch,
  tgh_cfg_if.sink   cfg_ch
);

  localparam int unsigned ECW = $clog2(MAX_EVENTS + 1);
  localparam int unsigned EIW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int unsigned HCW = $clog2(MAX_HOPS + 1);
  localparam int unsigned HIW = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
  localparam int unsigned FCW = $clog2(MAX_FREQS + 1);
  localparam int unsigned FIW = (MAX_FREQS > 1) ? $clog2(MAX_FREQS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_EV_RD, S_EV_CHK, S_HF_RD, S_HF_CHK, S_HB_RD, S_HB_CHK,
    S_DIV1, S_DIV2, S_FQ_RD, S_FQ_CHK, S_DONE
  } state_e;

  // tables
  logic [SAMPLE_W:0]   ev_mem    [MAX_EVENTS];
  logic [SAMPLE_W-1:0] hs_mem    [MAX_HOPS];
  logic [SAMPLE_W-1:0] hd_mem    [MAX_HOPS];
  logic [FCW-1:0]      hf_mem    [MAX_HOPS];
  logic [FCW-1:0]      hl_mem    [MAX_HOPS];
  logic [FREQ_W-1:0]   fq_mem    [MAX_FREQS];

  logic [SAMPLE_W:0]   ev_rd_q;
  logic [SAMPLE_W-1:0] hs_rd_q, hd_rd_q;
  logic [FCW-1:0]      hf_rd_q, hl_rd_q;
  logic [FREQ_W-1:0]   fq_rd_q;

  state_e              state_q;
  logic [FREQ_W-1:0]   base_q;
  logic [ECW-1:0]      ec_q;
  logic [HCW-1:0]      hc_q;
  logic [FCW-1:0]      fc_q;
  logic [SAMPLE_W-1:0] last_es_q;
  logic                last_est_q;
  logic [SAMPLE_W-1:0] last_hs_q;
  logic                newest_seq_q;
  logic [FCW-1:0]      newest_len_q;

  logic [SAMPLE_W-1:0] n_q;
  logic                on_q, has_q, prev_q, bnd_done_q, do_bnd_q;
  logic [SAMPLE_W-1:0] next_q;
  logic [FREQ_W-1:0]   cen_q;
  logic [ECW-1:0]      ek_q;
  logic [HCW-1:0]      hfi_q, hbi_q;
  logic [FCW-1:0]      fidx_q;

  logic                ov_q;
  logic                ov_set;
  logic [STATUS_W-1:0] o_status_q;
  logic                o_on_q, o_has_q;
  logic [FREQ_W-1:0]   o_cen_q;
  logic [SAMPLE_W-1:0] o_next_q;

  // load decode
  logic                accept;
  status_e             ld_status;
  logic                ev_we, hop_we, len_we, fq_we;
  logic [HIW-1:0]      len_waddr;
  logic [FCW-1:0]      len_wdata;

  logic [HCW-1:0]      hb_m1;
  logic [HIW-1:0]      hop_addr;
  logic [EIW-1:0]      ev_addr;
  logic [ECW-1:0]      ek_p1;
  logic [HCW-1:0]      hf_p1;
  logic [SAMPLE_W:0]   bnd;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  function automatic logic [HIW-1:0] hb_last();
    logic [HCW-1:0] t;
    t = hc_q - 1'b1;
    return t[HIW-1:0];
  endfunction

  assign in_ch.ready  = (state_q == S_IDLE) && (!ov_q || out_ch.ready);
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;

  // a new result beat is loaded into the output register this cycle
  assign ov_set = (state_q == S_IDLE && accept && kind_e'(in_ch.kind) != KIND_QUERY) ||
                  (state_q == S_DONE && (!ov_q || out_ch.ready));

  always_comb begin
    ld_status = ST_OK;
    ev_we     = 1'b0;
    hop_we    = 1'b0;
    len_we    = 1'b0;
    fq_we     = 1'b0;
    len_waddr = hc_q[HIW-1:0];
    len_wdata = '0;
    unique case (kind_e'(in_ch.kind))
      KIND_EVENT: begin
        if (ec_q != '0 && last_es_q == in_ch.sample_index) begin
          ld_status = (last_est_q == in_ch.tx_state) ? ST_OK : ST_CONFLICT;
        end else if (ec_q >= ECW'(MAX_EVENTS)) begin
          ld_status = ST_FULL;
        end else begin
          ev_we = 1'b1;
        end
      end
      KIND_HOP: begin
        if (!in_ch.fixed_center && in_ch.dwell_samples == '0) begin
          ld_status = ST_ZERO_DWELL;
        end else if (hc_q != '0 && last_hs_q == in_ch.sample_index) begin
          ld_status = ST_REPEAT;
        end else if (hc_q >= HCW'(MAX_HOPS)) begin
          ld_status = ST_FULL;
        end else if (in_ch.fixed_center && fc_q >= FCW'(MAX_FREQS)) begin
          ld_status = ST_FULL;
        end else begin
          hop_we    = 1'b1;
          len_we    = 1'b1;
          len_wdata = in_ch.fixed_center ? FCW'(1) : '0;
          fq_we     = in_ch.fixed_center;
        end
      end
      KIND_ENTRY: begin
        if (hc_q == '0 || !newest_seq_q) begin
          ld_status = ST_OK;
        end else if (fc_q >= FCW'(MAX_FREQS)) begin
          ld_status = ST_FULL;
        end else begin
          fq_we     = 1'b1;
          len_we    = 1'b1;
          len_waddr = hb_last();
          len_wdata = newest_len_q + 1'b1;
        end
      end
      default: ld_status = ST_OK;
    endcase
  end

  // memory writes and registered reads
  always_ff @(posedge clk_i) begin
    if (accept && ev_we) begin
      ev_mem[ec_q[EIW-1:0]] <= {in_ch.sample_index, in_ch.tx_state};
    end
    if (accept && hop_we) begin
      hs_mem[hc_q[HIW-1:0]] <= in_ch.sample_index;
      hd_mem[hc_q[HIW-1:0]] <= in_ch.fixed_center ? '0 : in_ch.dwell_samples;
      hf_mem[hc_q[HIW-1:0]] <= fc_q;
    end
    if (accept && len_we) begin
      hl_mem[len_waddr] <= len_wdata;
    end
    if (accept && fq_we) begin
      fq_mem[fc_q[FIW-1:0]] <= in_ch.frequency;
    end
    ev_rd_q <= ev_mem[ev_addr];
    hs_rd_q <= hs_mem[hop_addr];
    hd_rd_q <= hd_mem[hop_addr];
    hf_rd_q <= hf_mem[hop_addr];
    hl_rd_q <= hl_mem[hop_addr];
    fq_rd_q <= fq_mem[fidx_q[FIW-1:0]];
  end

  assign hb_m1    = hbi_q - 1'b1;
  assign hop_addr = (state_q == S_HF_RD || state_q == S_HF_CHK) ? hfi_q[HIW-1:0]
                                                                 : hb_m1[HIW-1:0];
  assign ev_addr  = ek_q[EIW-1:0];
  assign ek_p1    = ek_q + 1'b1;
  assign hf_p1    = hfi_q + 1'b1;

  // next dwell boundary = n - ((n - start) mod dwell) + dwell
  assign bnd = {1'b0, n_q} - {1'b0, div_rsp.rem} + {1'b0, hd_rd_q};

  always_comb begin
    div_req = '{start: 1'b0, dividend: n_q - hs_rd_q, divisor: hd_rd_q};
    if (state_q == S_HB_CHK) begin
      div_req.start = (hs_rd_q <= n_q) && (hl_rd_q > FCW'(1)) && (hd_rd_q != '0);
    end else if (state_q == S_DIV1 && div_rsp.done) begin
      div_req.start    = 1'b1;
      div_req.dividend = div_rsp.quot;
      div_req.divisor  = SAMPLE_W'(hl_rd_q);
    end
  end

  tgh_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      base_q       <= '0;
      ec_q         <= '0;
      hc_q         <= '0;
      fc_q         <= '0;
      ov_q         <= 1'b0;
      last_es_q    <= '0;
      last_est_q   <= 1'b0;
      last_hs_q    <= '0;
      newest_seq_q <= 1'b0;
      newest_len_q <= '0;
      n_q          <= '0;
      on_q         <= 1'b0;
      has_q        <= 1'b0;
      prev_q       <= 1'b0;
      bnd_done_q   <= 1'b0;
      do_bnd_q     <= 1'b0;
      next_q       <= '0;
      cen_q        <= '0;
      ek_q         <= '0;
      hfi_q        <= '0;
      hbi_q        <= '0;
      fidx_q       <= '0;
      o_status_q   <= '0;
      o_on_q       <= 1'b0;
      o_has_q      <= 1'b0;
      o_cen_q      <= '0;
      o_next_q     <= '0;
    end else begin
      if (cfg_ch.valid) begin
        base_q <= cfg_ch.data;
      end
      ov_q <= ov_set || (ov_q && !out_ch.ready);
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (kind_e'(in_ch.kind) == KIND_QUERY) begin
              n_q        <= in_ch.sample_index;
              on_q       <= 1'b1;
              has_q      <= 1'b0;
              next_q     <= '0;
              cen_q      <= base_q;
              prev_q     <= 1'b0;
              bnd_done_q <= 1'b0;
              ek_q       <= '0;
              hfi_q      <= '0;
              hbi_q      <= hc_q;
              if (ec_q != '0) begin
                state_q <= S_EV_RD;
              end else if (hc_q != '0) begin
                state_q <= S_HF_RD;
              end else begin
                state_q <= S_DONE;
              end
            end else begin
              o_status_q <= ld_status;
              o_on_q     <= 1'b0;
              o_has_q    <= 1'b0;
              o_cen_q    <= '0;
              o_next_q   <= '0;
              if (kind_e'(in_ch.kind) == KIND_CLEAR) begin
                ec_q <= '0;
                hc_q <= '0;
                fc_q <= '0;
              end
              if (ev_we) begin
                ec_q       <= ec_q + 1'b1;
                last_es_q  <= in_ch.sample_index;
                last_est_q <= in_ch.tx_state;
              end
              if (hop_we) begin
                hc_q         <= hc_q + 1'b1;
                last_hs_q    <= in_ch.sample_index;
                newest_seq_q <= !in_ch.fixed_center;
                newest_len_q <= len_wdata;
              end
              if (fq_we) begin
                fc_q <= fc_q + 1'b1;
              end
              if (len_we && !hop_we) begin
                newest_len_q <= len_wdata;
              end
            end
          end
        end
        S_EV_RD: state_q <= S_EV_CHK;
        S_EV_CHK: begin
          if (ev_rd_q[SAMPLE_W:1] > n_q) begin
            // first event past n; the one before it is in force
            on_q    <= (ek_q == '0) ? 1'b0 : prev_q;
            next_q  <= ev_rd_q[SAMPLE_W:1];
            has_q   <= 1'b1;
            state_q <= (hc_q != '0) ? S_HF_RD : S_DONE;
          end else begin
            prev_q <= ev_rd_q[0];
            ek_q   <= ek_p1;
            if (ek_p1 == ec_q) begin
              on_q    <= ev_rd_q[0];
              state_q <= (hc_q != '0) ? S_HF_RD : S_DONE;
            end else begin
              state_q <= S_EV_RD;
            end
          end
        end
        S_HF_RD: state_q <= S_HF_CHK;
        S_HF_CHK: begin
          if (hs_rd_q > n_q) begin
            if (!has_q || hs_rd_q < next_q) begin
              next_q <= hs_rd_q;
              has_q  <= 1'b1;
            end
            state_q <= S_HB_RD;
          end else begin
            hfi_q   <= hf_p1;
            state_q <= (hf_p1 == hc_q) ? S_HB_RD : S_HF_RD;
          end
        end
        S_HB_RD: state_q <= S_HB_CHK;
        S_HB_CHK: begin
          if (hs_rd_q > n_q || (hl_rd_q == '0 && bnd_done_q)) begin
            hbi_q   <= hb_m1;
            state_q <= (hb_m1 == '0) ? S_DONE : S_HB_RD;
          end else begin
            bnd_done_q <= 1'b1;
            if (hl_rd_q == '0) begin
              // newest started hop has no entries yet: look further back
              hbi_q   <= hb_m1;
              state_q <= (hb_m1 == '0) ? S_DONE : S_HB_RD;
            end else if (hd_rd_q == '0 || hl_rd_q == FCW'(1)) begin
              fidx_q  <= hf_rd_q;
              state_q <= S_FQ_RD;
            end else begin
              do_bnd_q <= !bnd_done_q;
              state_q  <= S_DIV1;
            end
          end
        end
        S_DIV1: begin
          if (div_rsp.done) begin
            if (do_bnd_q && !bnd[SAMPLE_W] &&
                (!has_q || bnd[SAMPLE_W-1:0] < next_q)) begin
              next_q <= bnd[SAMPLE_W-1:0];
              has_q  <= 1'b1;
            end
            state_q <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_rsp.done) begin
            fidx_q  <= hf_rd_q + div_rsp.rem[FCW-1:0];
            state_q <= S_FQ_RD;
          end
        end
        S_FQ_RD: state_q <= S_FQ_CHK;
        S_FQ_CHK: begin
          cen_q   <= fq_rd_q;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!ov_q || out_ch.ready) begin
            o_status_q <= ST_OK;
            o_on_q     <= on_q;
            o_cen_q    <= cen_q;
            o_has_q    <= has_q;
            o_next_q   <= has_q ? next_q : '0;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid            = ov_q;
  assign out_ch.status           = o_status_q;
  assign out_ch.tx_on            = o_on_q;
  assign out_ch.center_frequency = o_cen_q;
  assign out_ch.next_change      = o_next_q;
  assign out_ch.has_next_change  = o_has_q;

`ifndef NO_ASSERTIONS
  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ec_q <= ECW'(MAX_EVENTS) && hc_q <= HCW'(MAX_HOPS) && fc_q <= FCW'(MAX_FREQS))
    else $error("table count beyond capacity");
  a_div_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");
  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_ch.ready)
    else $error("input taken during a query");
  a_beat_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ch.ready) |=> ov_q)
    else $error("result beat dropped while stalled");
`endif

endmodule

### design/tgh_div.sv
// ----------------------------------------------------------------------------
// tgh_div
// Restoring divider, one quotient bit per cycle, 48-bit operands.
// ----------------------------------------------------------------------------
module tgh_div
  import tgh_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [SAMPLE_W-1:0]  rem_q, rem_d;
  logic [SAMPLE_W-1:0]  quo_q, quo_d;
  logic [SAMPLE_W-1:0]  dvs_q, dvs_d;
  logic [SAMPLE_W:0]    trial;
  logic [SAMPLE_W+1:0]  diff;
  logic                 ge;

  assign trial = {rem_q, quo_q[SAMPLE_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};
  assign ge    = ~diff[SAMPLE_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(SAMPLE_W);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
      quo_d = {quo_q[SAMPLE_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o = '{busy: busy_q, done: done_q, quot: quo_q, rem: rem_q};

endmodule

### dv/tgh_tb_if.sv
// ----------------------------------------------------------------------------
// tgh_tb_if
// Beat record types shared by the driver, the predictor and the checker.
// ----------------------------------------------------------------------------
package tgh_tb_pkg;
  import tgh_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SAMPLE_W-1:0] sample_index;
    logic                tx_state;
    logic                fixed_center;
    logic [SAMPLE_W-1:0] dwell_samples;
    logic [FREQ_W-1:0]   frequency;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                tx_on;
    logic [FREQ_W-1:0]   center_frequency;
    logic [SAMPLE_W-1:0] next_change;
    logic                has_next_change;
  } answer_t;

endpackage

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives load, clear, query and unknown-kind beats into the timeline engine, predicts every
// answer from its own copy of the event, hop and frequency tables, and checks
// each output beat in order under random idling and a long output stall.
// ----------------------------------------------------------------------------
module testbench;
  import tgh_pkg::*;
  import tgh_tb_pkg::*;

  localparam int NEV = MAX_EVENTS_DEF;
  localparam int NHOP = MAX_HOPS_DEF;
  localparam int NFRQ = MAX_FREQS_DEF;
  localparam logic [SAMPLE_W-1:0] SMAX = '1;
  localparam logic [FREQ_W-1:0] FMAX = '1;
  localparam longint LIMIT = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tgh_in_if  in_ch ();
  tgh_out_if out_ch ();
  tgh_cfg_if cfg_ch ();

  tx_gate_and_hop_schedule dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [FREQ_W-1:0]   base_freq;
  logic [SAMPLE_W-1:0] ev_smp [NEV];
  logic                ev_st [NEV];
  int                  ev_cnt;
  logic [SAMPLE_W-1:0] hop_start [NHOP];
  logic [SAMPLE_W-1:0] hop_dwell [NHOP];
  int                  hop_first [NHOP];
  int                  hop_len [NHOP];
  int                  hop_cnt;
  logic [FREQ_W-1:0]   freqs [NFRQ];
  int                  freq_cnt;

  item_t   pending [$];
  answer_t expected [$];
  int      errors, n_acc, n_out, n_query, n_full, n_err_st;
  longint  cycles;
  bit      quiet, hold_req;
  int      hold_left;

  function automatic answer_t timeline_answer(item_t it);
    answer_t a;
    logic [SAMPLE_W-1:0] n, nxt, q;
    logic [SAMPLE_W:0] b;
    logic [2*SAMPLE_W:0] prod;
    bit has;
    int k;
    a = '0;
    n = it.sample_index;
    case (it.kind)
      KIND_CLEAR: begin
        ev_cnt = 0; hop_cnt = 0; freq_cnt = 0;
      end
      KIND_EVENT: begin
        if (ev_cnt > 0 && ev_smp[ev_cnt-1] == n)
          a.status = (ev_st[ev_cnt-1] == it.tx_state) ? ST_OK : ST_CONFLICT;
        else if (ev_cnt >= NEV) a.status = ST_FULL;
        else begin
          ev_smp[ev_cnt] = n; ev_st[ev_cnt] = it.tx_state; ev_cnt++;
        end
      end
      KIND_HOP: begin
        if (!it.fixed_center && it.dwell_samples == 0) a.status = ST_ZERO_DWELL;
        else if (hop_cnt > 0 && hop_start[hop_cnt-1] == n) a.status = ST_REPEAT;
        else if (hop_cnt >= NHOP) a.status = ST_FULL;
        else if (it.fixed_center && freq_cnt >= NFRQ) a.status = ST_FULL;
        else begin
          hop_start[hop_cnt] = n;
          hop_first[hop_cnt] = freq_cnt;
          if (it.fixed_center) begin
            hop_dwell[hop_cnt] = '0; hop_len[hop_cnt] = 1;
            freqs[freq_cnt] = it.frequency; freq_cnt++;
          end else begin
            hop_dwell[hop_cnt] = it.dwell_samples; hop_len[hop_cnt] = 0;
          end
          hop_cnt++;
        end
      end
      KIND_ENTRY: begin
        if (hop_cnt == 0 || hop_dwell[hop_cnt-1] == 0) a.status = ST_OK;
        else if (freq_cnt >= NFRQ) a.status = ST_FULL;
        else begin
          freqs[freq_cnt] = it.frequency; freq_cnt++; hop_len[hop_cnt-1]++;
        end
      end
      KIND_QUERY: begin
        a.tx_on = 1'b1; a.center_frequency = base_freq;
        has = 0; nxt = '0;
        if (ev_cnt > 0) begin
          k = 0;
          while (k < ev_cnt && ev_smp[k] <= n) k++;
          a.tx_on = (k == 0) ? 1'b0 : ev_st[k-1];
          if (k < ev_cnt) begin nxt = ev_smp[k]; has = 1; end
        end
        for (int i = hop_cnt - 1; i >= 0; i--) begin
          if (hop_start[i] > n || hop_len[i] == 0) continue;
          if (hop_dwell[i] == 0) a.center_frequency = freqs[hop_first[i]];
          else begin
            q = (n - hop_start[i]) / hop_dwell[i];
            a.center_frequency = freqs[hop_first[i] + int'(q % hop_len[i])];
          end
          break;
        end
        for (int i = 0; i < hop_cnt; i++)
          if (hop_start[i] > n) begin
            if (!has || hop_start[i] < nxt) begin nxt = hop_start[i]; has = 1; end
            break;
          end
        for (int i = hop_cnt - 1; i >= 0; i--) begin
          if (hop_start[i] > n) continue;
          if (hop_dwell[i] == 0 || hop_len[i] <= 1) break;
          q = (n - hop_start[i]) / hop_dwell[i];
          prod = ({49'b0, q} + 1) * hop_dwell[i] + hop_start[i];
          if (prod <= SMAX && (!has || prod[SAMPLE_W-1:0] < nxt)) begin
            nxt = prod[SAMPLE_W-1:0]; has = 1;
          end
          break;
        end
        a.has_next_change = has;
        a.next_change = has ? nxt : '0;
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch beat %0d %s: got %0h want %0h", n_out, what, got, want);
  endtask

  // driver
  int gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0; gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (pending[0].kind == KIND_QUERY) n_query++;
        expected.insert(expected.size(), timeline_answer(pending.pop_front()));
        n_acc++;
      end
      if (in_ch.valid && !(in_ch.ready)) begin
        // hold the beat
      end else if (gap > 0) begin
        gap--; in_ch.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 13) - 1; in_ch.valid <= 1'b0;
      end else if (pending.size() > (in_ch.valid && in_ch.ready ? 0 : 0)) begin
        in_ch.valid <= 1'b1;
        {in_ch.kind, in_ch.sample_index, in_ch.tx_state, in_ch.fixed_center,
         in_ch.dwell_samples, in_ch.frequency} <= pending[0];
      end else in_ch.valid <= 1'b0;
    end
  end

  // long receiver hold, counted on its own
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_req = 0; hold_left <= 400;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor / checker
  int sgap;
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t g, w;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0; sgap = 0;
    end else begin
      cycles++;
      if (out_ch.valid && out_ch.ready) begin
        g = {out_ch.status, out_ch.tx_on, out_ch.center_frequency,
             out_ch.next_change, out_ch.has_next_change};
        if (expected.size() == 0) report("unexpected beat", g.status, 0);
        else begin
          w = expected.pop_front();
          if (g.status !== w.status) report("status", g.status, w.status);
          if (g.tx_on !== w.tx_on) report("tx_on", g.tx_on, w.tx_on);
          if (g.center_frequency !== w.center_frequency)
            report("center_frequency", g.center_frequency, w.center_frequency);
          if (g.next_change !== w.next_change)
            report("next_change", g.next_change, w.next_change);
          if (g.has_next_change !== w.has_next_change)
            report("has_next_change", g.has_next_change, w.has_next_change);
          if (w.status == ST_FULL) n_full++;
          if (w.status != ST_OK) n_err_st++;
        end
        n_out++;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else if (sgap > 0) begin
        sgap--; out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        sgap = $urandom_range(1, 13) - 1; out_ch.ready <= 1'b0;
      end else out_ch.ready <= 1'b1;
    end
  end

  function automatic logic [SAMPLE_W-1:0] rnd_sample(int mode);
    case (mode)
      0: return SMAX - $urandom_range(0, 3);
      1: return {$urandom, $urandom} & SMAX;
      default: return SAMPLE_W'($urandom_range(0, 2000));
    endcase
  endfunction

  function automatic item_t mk(kind_e k, logic [SAMPLE_W-1:0] s, bit st, bit fx,
                               logic [SAMPLE_W-1:0] d, logic [FREQ_W-1:0] f);
    item_t it;
    it.kind = k; it.sample_index = s; it.tx_state = st; it.fixed_center = fx;
    it.dwell_samples = d; it.frequency = f;
    return it;
  endfunction

  function automatic void add_item(item_t it);
    pending.insert(pending.size(), it);
  endfunction

  task automatic drain(bit lat);
    while (pending.size() > 0 || expected.size() > 0 || in_ch.valid)
      @(posedge clk_i);
    if (lat) repeat (400) @(posedge clk_i);
  endtask

  task automatic write_base(logic [FREQ_W-1:0] v);
    cfg_ch.valid <= 1'b1; cfg_ch.data <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    base_freq = v;
  endtask

  // one random schedule, possibly with malformed items, and a few queries
  task automatic push_schedule();
    logic [SAMPLE_W-1:0] t, span;
    int m;
    t = rnd_sample(2 + ($urandom_range(0, 3) == 0 ? -1 : 0));
    span = ($urandom_range(0, 7) == 0) ? SMAX : SAMPLE_W'($urandom_range(1, 5000));
    if ($urandom_range(0, 3) != 0) add_item(mk(KIND_CLEAR, 0, 0, 0, 0, 0));
    m = $urandom_range(0, 8);
    for (int i = 0; i < m; i++) begin
      t = t + $urandom_range(0, 300);
      add_item(mk(KIND_EVENT, $urandom_range(0, 5) == 0 ?
                  rnd_sample(1) : t, $urandom, 0, 0, 0));
    end
    m = $urandom_range(0, 5);
    for (int i = 0; i < m; i++) begin
      t = t + $urandom_range(0, 400);
      if ($urandom_range(0, 2) == 0)
        add_item(mk(KIND_HOP, t, 0, 1, rnd_sample(1), {$urandom, $urandom}));
      else begin
        add_item(mk(KIND_HOP, t, 0, 0,
                    $urandom_range(0, 9) == 0 ? 0 :
                    $urandom_range(0, 9) == 0 ? rnd_sample(1) :
                    SAMPLE_W'($urandom_range(1, 60)), 0));
        repeat ($urandom_range(0, 6))
          add_item(mk(KIND_ENTRY, 0, 0, 0, 0, {$urandom, $urandom}));
      end
    end
    repeat ($urandom_range(1, 6))
      add_item(mk(KIND_QUERY, $urandom_range(0, 4) == 0 ? rnd_sample(1) :
                  t - span / 2 + $urandom_range(0, 3000), 0, 0, 0, 0));
    if ($urandom_range(0, 15) == 0)
      add_item(mk(kind_e'($urandom_range(5, 7)), rnd_sample(1), $urandom,
                  $urandom, rnd_sample(1), {$urandom, $urandom}));
    if ($urandom_range(0, 12) == 0)
      add_item(mk(kind_e'($urandom_range(0, 7)), rnd_sample(1), $urandom,
                  $urandom, rnd_sample(1), {$urandom, $urandom}));
  endtask

  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0; in_ch.kind = '0; in_ch.sample_index = '0;
    in_ch.tx_state = 1'b0; in_ch.fixed_center = 1'b0; in_ch.dwell_samples = '0;
    in_ch.frequency = '0;
    out_ch.ready = 1'b0; cfg_ch.valid = 1'b0; cfg_ch.data = '0;
    base_freq = '0; ev_cnt = 0; hop_cnt = 0; freq_cnt = 0;
    errors = 0; n_acc = 0; n_out = 0; n_query = 0; n_full = 0; n_err_st = 0;
    cycles = 0; quiet = 0; hold_req = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty tables, extremes, every check
    add_item(mk(KIND_QUERY, 0, 0, 0, 0, 0));
    add_item(mk(KIND_QUERY, SMAX, 0, 0, 0, 0));
    drain(0);
    write_base(FMAX);
    add_item(mk(KIND_ENTRY, 0, 0, 0, 0, FMAX));          // no hop yet
    add_item(mk(KIND_EVENT, 100, 1, 0, 0, 0));
    add_item(mk(KIND_EVENT, 100, 1, 0, 0, 0));           // same state
    add_item(mk(KIND_EVENT, 100, 0, 0, 0, 0));           // conflict
    add_item(mk(KIND_EVENT, 50, 0, 0, 0, 0));            // unsorted
    add_item(mk(KIND_EVENT, SMAX, 0, 0, 0, 0));
    add_item(mk(KIND_HOP, 10, 0, 0, 0, 0));              // zero dwell
    add_item(mk(KIND_HOP, 10, 0, 1, SMAX, FMAX));        // fixed
    add_item(mk(KIND_ENTRY, 0, 0, 0, 0, 5));             // newest fixed
    add_item(mk(KIND_HOP, 10, 0, 0, 7, 0));              // repeat
    add_item(mk(KIND_HOP, 20, 0, 0, SMAX, 0));           // empty sequence
    add_item(mk(KIND_HOP, 200, 0, 0, 7, 0));
    add_item(mk(KIND_ENTRY, 0, 0, 0, 0, 0));
    add_item(mk(KIND_ENTRY, 0, 0, 0, 0, FMAX));
    add_item(mk(KIND_ENTRY, 0, 0, 0, 0, 123));
    for (int s = 0; s < 5; s++)
      add_item(mk(KIND_QUERY, s == 4 ? SMAX : 48'(s * 60), 0, 0, 0, 0));
    add_item(mk(KIND_HOP, SMAX - 2, 0, 0, 3, 0));         // boundary past 48 bits
    add_item(mk(KIND_ENTRY, 0, 0, 0, 0, 9));
    add_item(mk(KIND_ENTRY, 0, 0, 0, 0, 8));
    add_item(mk(kind_e'(7), SMAX, 1, 1, SMAX, FMAX));
    add_item(mk(KIND_QUERY, SMAX - 1, 0, 0, 0, 0));
    drain(1);

    // fill every table to overflow
    write_base('0);
    add_item(mk(KIND_CLEAR, 0, 0, 0, 0, 0));
    for (int i = 0; i <= NEV; i++)
      add_item(mk(KIND_EVENT, 48'(i * 3), i[0], 0, 0, 0));
    for (int i = 0; i <= NHOP; i++) begin
      add_item(mk(KIND_HOP, 48'(i * 10), 0, 0, 2, 0));
      repeat (5) add_item(mk(KIND_ENTRY, 0, 0, 0, 0, {$urandom, $urandom}));
    end
    for (int i = 0; i < 8; i++)
      add_item(mk(KIND_QUERY, 48'(i * 23), 0, 0, 0, 0));
    add_item(mk(KIND_CLEAR, 0, 0, 0, 0, 0));
    add_item(mk(KIND_HOP, 0, 0, 0, 1, 0));
    repeat (NFRQ) add_item(mk(KIND_ENTRY, 0, 0, 0, 0, {$urandom, $urandom}));
    add_item(mk(KIND_HOP, 5, 0, 1, 0, 1));                // store full
    add_item(mk(KIND_QUERY, 70, 0, 0, 0, 0));
    hold_req = 1;
    drain(1);

    // random phases with different base settings
    for (int ph = 0; ph < 4; ph++) begin
      write_base(ph == 3 ? FMAX : {$urandom, $urandom});
      while (pending.size() + n_acc < 360 * (ph + 1) + 60) push_schedule();
      if (ph == 1) hold_req = 1;
      if (ph == 3) begin
        while (pending.size() > 150) @(posedge clk_i);
        quiet = 1;
      end
      drain(1);
    end

    $display("covered %0d beats (%0d queries); %0d non-ok status answers, %0d table-full",
             n_acc, n_query, n_err_st, n_full);
    if (errors == 0 && expected.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### files.f
design/tgh_pkg.sv
design/tgh_if.sv
design/tgh_div.sv
design/tx_gate_and_hop_schedule.sv
dv/tgh_tb_if.sv
dv/testbench.sv
